FILE: sv/aeskc_pkg.sv
package aeskc_pkg;

	localparam int CounterBitsDefault = 32;
	localparam int AesRounds = 10;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_word;
		logic [3:0]  out_bytes;
		logic        out_last;
	} out_item_t;

	localparam logic [2:0] RegKeyHigh   = 3'd0;
	localparam logic [2:0] RegKeyLow    = 3'd1;
	localparam logic [2:0] RegCount     = 3'd2;
	localparam logic [2:0] RegBearer    = 3'd3;
	localparam logic [2:0] RegDirection = 3'd4;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

FILE: sv/aeskc_round.sv
module aeskc_round (
	input  logic [127:0] state_in,
	input  logic [127:0] key_in,
	input  logic [7:0]   rcon,
	input  logic         final_round,
	output logic [127:0] state_out,
	output logic [127:0] key_out
);
	import aeskc_pkg::*;

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] k [16];
	logic [7:0] nk [16];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state_in[127-8*i -: 8];
			k[i] = key_in[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[c*4+r] = sbox(s[((c+r)&3)*4+r]);
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				m[c*4+r] = final_round ? t[c*4+r] :
					t[c*4+r] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3])
					^ xtime(t[c*4+r] ^ t[c*4+((r+1)&3)]);
			end
		end
		nk[0] = k[0] ^ sbox(k[13]) ^ rcon;
		nk[1] = k[1] ^ sbox(k[14]);
		nk[2] = k[2] ^ sbox(k[15]);
		nk[3] = k[3] ^ sbox(k[12]);
		for (int i = 4; i < 16; i++)
			nk[i] = k[i] ^ nk[i-4];
		for (int i = 0; i < 16; i++) begin
			state_out[127-8*i -: 8] = m[i] ^ nk[i];
			key_out[127-8*i -: 8] = nk[i];
		end
	end
endmodule

FILE: sv/aeskc_core.sv
module aeskc_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] block_in,
	input  logic [127:0] key,
	output logic         done,
	output logic [127:0] block_out
);
	import aeskc_pkg::*;

	logic [127:0] state_q, key_q, nstate, nkey;
	logic [3:0]   round_q;
	logic [7:0]   rcon_q;
	logic         busy_q;

	aeskc_round u_round (
		.state_in(state_q), .key_in(key_q), .rcon(rcon_q),
		.final_round(round_q == 4'(AesRounds)),
		.state_out(nstate), .key_out(nkey)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done    <= 1'b0;
			round_q <= '0;
			rcon_q  <= 8'h01;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				round_q <= 4'd1;
				rcon_q  <= 8'h01;
			end else if (busy_q) begin
				rcon_q  <= xtime(rcon_q);
				round_q <= round_q + 4'd1;
				if (round_q == 4'(AesRounds)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= block_in ^ key;
			key_q   <= key;
		end else if (busy_q) begin
			state_q <= nstate;
			key_q   <= nkey;
		end
	end

	assign block_out = state_q;
endmodule

FILE: sv/aes_ctr_keystream_cipher.sv
// lte 128-eea2 keystream cipher: aes-128 counter mode over 64-bit words. the first word of
// each pair starts one aes-128 block on a single shared round unit, which runs ten rounds in
// turn. that word then waits in the aes state until the block is done and moves on to the
// output state; the next word can be taken only once that result is taken. the second word
// of the pair reuses the stored keystream half and goes straight from idle to the output
// state. one word is in flight at a time; a result waits in the output register until taken.
// registers sit on the apb port at 8*index; key, count, bearer and direction are sampled when
// a new counter block starts. counter block: count, bearer<<3|direction<<2, zeros, then the
// block counter big-endian in bytes 8..15, cleared after each last word.
module aes_ctr_keystream_cipher #(
	parameter int COUNTER_BITS = aeskc_pkg::CounterBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  aeskc_pkg::in_item_t in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output aeskc_pkg::out_item_t out_data
);
	import aeskc_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StAes  = 2'd1;
	localparam logic [1:0] StOut  = 2'd2;

	// configuration registers
	logic [63:0] key_high_q, key_low_q;
	logic [31:0] count_q;
	logic [4:0]  bearer_q;
	logic        dir_q;
	logic [2:0]  reg_idx;

	// sequencing
	logic [1:0]              state_q;
	logic [COUNTER_BITS-1:0] ctr_q;
	logic                    half_q;
	logic [63:0]             ks_hi_q, ks_lo_q;
	in_item_t                item_q;
	logic                    in_fire, out_fire, aes_start, aes_done;
	logic [127:0]            ctr_block, aes_out;
	logic [63:0]             ctr_wide;
	logic [3:0]              nb;
	logic [63:0]             mask, ks;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			count_q    <= '0;
			bearer_q   <= '0;
			dir_q      <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				RegKeyHigh:   key_high_q <= pwdata;
				RegKeyLow:    key_low_q  <= pwdata;
				RegCount:     count_q    <= pwdata[31:0];
				RegBearer:    bearer_q   <= pwdata[4:0];
				RegDirection: dir_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegKeyHigh:   prdata = key_high_q;
			RegKeyLow:    prdata = key_low_q;
			RegCount:     prdata = {32'd0, count_q};
			RegBearer:    prdata = {59'd0, bearer_q};
			RegDirection: prdata = {63'd0, dir_q};
			default:      prdata = '0;
		endcase
	end

	// a word is taken only while idle; the output register holds one result
	assign in_stall  = (state_q != StIdle);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = (state_q == StOut);
	assign out_fire  = out_valid && !out_stall;
	// first half of a pair kicks off a fresh counter block
	assign aes_start = in_fire && !half_q;

	assign ctr_wide  = 64'(ctr_q);
	assign ctr_block = {count_q, bearer_q, dir_q, 2'b00, 24'd0, ctr_wide};

	aeskc_core u_core (
		.clk(clk), .arst_n(arst_n), .start(aes_start),
		.block_in(ctr_block), .key({key_high_q, key_low_q}),
		.done(aes_done), .block_out(aes_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			ctr_q   <= '0;
			half_q  <= 1'b0;
		end else begin
			unique case (state_q)
				StIdle: if (in_fire) begin
					state_q <= half_q ? StOut : StAes;
				end
				StAes: if (aes_done) begin
					state_q <= StOut;
				end
				StOut: if (out_fire) begin
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
			// counter bookkeeping on the input transfer
			if (in_fire) begin
				if (in_data.last_word) begin
					ctr_q  <= '0;
					half_q <= 1'b0;
				end else begin
					half_q <= !half_q;
					if (half_q)
						ctr_q <= ctr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			item_q <= in_data;
		if (aes_done) begin
			ks_hi_q <= aes_out[127:64];
			ks_lo_q <= aes_out[63:0];
		end
	end

	// item_q holds the word; select the half by whether it opened a block
	logic first_half_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			first_half_q <= 1'b0;
		else if (in_fire)
			first_half_q <= !half_q;
	end

	always_comb begin
		if (item_q.byte_count == 4'd0)
			nb = 4'd1;
		else if (item_q.byte_count > 4'd8)
			nb = 4'd8;
		else
			nb = item_q.byte_count;
		mask = ~(64'hffff_ffff_ffff_ffff >> {nb, 3'b000});
		ks   = first_half_q ? ks_hi_q : ks_lo_q;
		out_data.out_word  = (item_q.data_word ^ ks) & mask;
		out_data.out_bytes = nb;
		out_data.out_last  = item_q.last_word;
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != StIdle) |-> in_stall)
		else $error("word taken while busy");
	a_done_in_aes: assert property (@(posedge clk) disable iff (!arst_n)
		aes_done |-> (state_q == StAes))
		else $error("aes result outside aes wait");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import aeskc_pkg::*;

	// clock, reset and block ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;

	// register shadow, written alongside every apb write
	logic [63:0] key_hi_q, key_lo_q;
	logic [31:0] count_q;
	logic [4:0]  bearer_q;
	logic        dir_q;

	// keystream tracking: current block halves, which half is next, word pair counter
	logic [63:0] ks_first, ks_second;
	logic        second_half_next;
	logic [31:0] pair_counter;

	logic [7:0]  sub_byte [256];
	in_item_t    pending_words [$];
	out_item_t   expected_words [$];
	int          send_gap, recv_gap;
	bit          calm_mode;
	bit          failed;
	int unsigned cycle_count;

	aes_ctr_keystream_cipher u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// gf(2^8) multiply, used both to build the s-box and for mixcolumns
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// s-box built from the field inverse and the affine map
	task automatic build_sub_bytes();
		logic [7:0] inv, r;
		for (int x = 0; x < 256; x++) begin
			inv = '0;
			for (int y = 1; y < 256; y++)
				if (gf_mul(x[7:0], y[7:0]) == 8'h01)
					inv = y[7:0];
			r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sub_byte[x] = r;
		end
	endtask

	// aes-128 encryption, bytes numbered from the top of the vector, column-major state
	function automatic logic [127:0] aes128(input logic [127:0] blk, input logic [127:0] key);
		logic [7:0] s [16];
		logic [7:0] k [16];
		logic [7:0] t [16];
		logic [7:0] rcon, a0, a1, a2, a3, g0, g1, g2, g3;
		logic [127:0] res;
		rcon = 8'h01;
		for (int i = 0; i < 16; i++) begin
			k[i] = key[127 - 8*i -: 8];
			s[i] = blk[127 - 8*i -: 8] ^ k[i];
		end
		for (int rnd = 1; rnd <= 10; rnd++) begin
			// subbytes and shiftrows together
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[c*4 + r] = sub_byte[s[((c + r) % 4)*4 + r]];
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
				if (rnd < 10) begin
					s[c*4]   = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
					s[c*4+1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
					s[c*4+2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
					s[c*4+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
				end else begin
					s[c*4] = a0; s[c*4+1] = a1; s[c*4+2] = a2; s[c*4+3] = a3;
				end
			end
			// next round key
			g0 = sub_byte[k[13]]; g1 = sub_byte[k[14]];
			g2 = sub_byte[k[15]]; g3 = sub_byte[k[12]];
			k[0] ^= g0 ^ rcon; k[1] ^= g1; k[2] ^= g2; k[3] ^= g3;
			for (int i = 4; i < 16; i++)
				k[i] ^= k[i-4];
			rcon = gf_mul(rcon, 8'h02);
			for (int i = 0; i < 16; i++)
				s[i] ^= k[i];
		end
		for (int i = 0; i < 16; i++)
			res[127 - 8*i -: 8] = s[i];
		return res;
	endfunction

	// works out the result of one accepted word and advances the keystream position
	task automatic cipher_word(input in_item_t w);
		logic [3:0]   nb;
		logic [63:0]  ks;
		logic [127:0] ctr_blk, ks_blk;
		out_item_t    r;
		nb = w.byte_count;
		if (nb == 4'd0)
			nb = 4'd1;
		if (nb > 4'd8)
			nb = 4'd8;
		if (!second_half_next) begin
			ctr_blk = {count_q, bearer_q, dir_q, 2'b00, 24'd0, 32'd0, pair_counter};
			ks_blk = aes128(ctr_blk, {key_hi_q, key_lo_q});
			ks_first = ks_blk[127:64];
			ks_second = ks_blk[63:0];
			ks = ks_first;
			second_half_next = 1'b1;
		end else begin
			ks = ks_second;
			second_half_next = 1'b0;
			pair_counter = pair_counter + 32'd1;
		end
		r.out_word = (w.data_word ^ ks) & (~64'd0 << (8 * (8 - nb)));
		r.out_bytes = nb;
		r.out_last = w.last_word;
		expected_words.push_back(r);
		if (w.last_word) begin
			pair_counter = '0;
			second_half_next = 1'b0;
		end
	endtask

	// register write: setup cycle then access cycle
	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegKeyHigh:   key_hi_q = val;
			RegKeyLow:    key_lo_q = val;
			RegCount:     count_q = val[31:0];
			RegBearer:    bearer_q = val[4:0];
			RegDirection: dir_q = val[0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [63:0] kh, input logic [63:0] kl,
			input logic [31:0] cnt, input logic [4:0] br, input logic dr);
		reg_write(RegKeyHigh, kh);
		reg_write(RegKeyLow, kl);
		reg_write(RegCount, {32'd0, cnt});
		reg_write(RegBearer, {59'd0, br});
		reg_write(RegDirection, {63'd0, dr});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// one message of random content; mostly well formed, a few odd byte counts
	task automatic queue_message(input int n_words);
		in_item_t w;
		int pick;
		for (int i = 0; i < n_words; i++) begin
			w.data_word = rand64();
			w.last_word = (i == n_words - 1);
			pick = $urandom_range(0, 19);
			if (pick == 0)
				w.byte_count = 4'($urandom_range(9, 15));
			else if (pick == 1)
				w.byte_count = 4'd0;
			else if (w.last_word || pick == 2)
				w.byte_count = 4'($urandom_range(1, 8));
			else
				w.byte_count = 4'd8;
			pending_words.push_back(w);
		end
	endtask

	// block must be drained before the registers move; checked once the edge has settled
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// stimulus sequencing
	initial begin
		in_item_t w;
		int issued;
		key_hi_q = '0; key_lo_q = '0; count_q = '0; bearer_q = '0; dir_q = '0;
		ks_first = '0; ks_second = '0; second_half_next = 1'b0; pair_counter = '0;
		calm_mode = 1'b0;
		failed = 1'b0;
		build_sub_bytes();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every byte count as a one-word message on extreme data, reset registers
		for (int bc = 0; bc < 16; bc++) begin
			w.data_word = bc[0] ? ~64'd0 : 64'd0;
			w.byte_count = 4'(bc);
			w.last_word = 1'b1;
			pending_words.push_back(w);
		end
		// a longer message with a short word in the middle and a long run past it
		for (int i = 0; i < 7; i++) begin
			w.data_word = (i % 2) ? 64'h0123_4567_89ab_cdef : ~64'd0;
			w.byte_count = (i == 2) ? 4'd3 : 4'd8;
			w.last_word = (i == 6);
			pending_words.push_back(w);
		end
		wait_drained();

		// extremes of every register, then all zero written explicitly
		write_all(~64'd0, ~64'd0, 32'hffff_ffff, 5'd31, 1'b1);
		for (int i = 0; i < 3; i++)
			queue_message($urandom_range(1, 6));
		wait_drained();
		write_all('0, '0, '0, '0, 1'b0);
		for (int i = 0; i < 3; i++)
			queue_message($urandom_range(1, 6));
		wait_drained();

		// random phases; a message may straddle a phase boundary
		for (int ph = 0; ph < 7; ph++) begin
			write_all(rand64(), rand64(), $urandom(), 5'($urandom_range(0, 31)),
				1'($urandom_range(0, 1)));
			if (ph == 6)
				calm_mode = 1'b1;
			issued = 0;
			while (issued < 220) begin
				int n;
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				queue_message(n);
				issued += n;
			end
			// unterminated tail so the next phase starts mid-pair
			if (ph < 6) begin
				w.data_word = rand64();
				w.byte_count = 4'd8;
				w.last_word = 1'b0;
				pending_words.push_back(w);
			end
			wait_drained();
		end

		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// word driver: valid held through stalls, random idle bursts between transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				cipher_word(in_data);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					if (!calm_mode && $urandom_range(0, 9) == 0) begin
						send_gap = $urandom_range(0, 10);
						in_valid <= 1'b0;
					end else begin
						in_valid <= 1'b1;
						in_data <= pending_words.pop_front();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end else begin
			send_gap = 0;
		end
	end

	// result monitor: random stall bursts, checks every field against the oldest prediction
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_data);
					failed = 1'b1;
				end else begin
					e = expected_words.pop_front();
					if (out_data.out_word !== e.out_word) begin
						$display("%0t: out_word expected %h actual %h", $time,
							e.out_word, out_data.out_word);
						failed = 1'b1;
					end
					if (out_data.out_bytes !== e.out_bytes) begin
						$display("%0t: out_bytes expected %0d actual %0d", $time,
							e.out_bytes, out_data.out_bytes);
						failed = 1'b1;
					end
					if (out_data.out_last !== e.out_last) begin
						$display("%0t: out_last expected %b actual %b", $time,
							e.out_last, out_data.out_last);
						failed = 1'b1;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (!calm_mode && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end else begin
			recv_gap = 0;
		end
	end

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

FILE: files.f
sv/aeskc_pkg.sv
sv/aeskc_round.sv
sv/aeskc_core.sv
sv/aes_ctr_keystream_cipher.sv
tb/tb_top.sv
